// File: sv/mel_pkg.sv
package mel_pkg;

  localparam int EVENT_DEPTH = 32;
  localparam int TIME_BITS   = 20;
  localparam int IDX_W       = $clog2(EVENT_DEPTH);
  localparam int CNT_W       = $clog2(EVENT_DEPTH + 1);
  localparam int MSG_W       = 24;
  localparam int BEAT_W      = 10;
  localparam int BARS_W      = 5;
  localparam int CMD_W       = 4;
  localparam int BEATS_PER_BAR = 4;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [BARS_W-1:0]    BARS_RESET = BARS_W'(4);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_CIN     = 3'd1,
    MODE_REC     = 3'd2,
    MODE_COUT    = 3'd3,
    MODE_PLAY    = 3'd4,
    MODE_CIN_DUB = 3'd5,
    MODE_DUB     = 3'd6
  } mode_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 4'd0,
    CMD_MIDI_IN   = 4'd1,
    CMD_START_REC = 4'd2,
    CMD_STOP_REC  = 4'd3,
    CMD_START_PLAY = 4'd4,
    CMD_START_DUB = 4'd5,
    CMD_STOP_DUB  = 4'd6,
    CMD_STOP_PLAY = 4'd7,
    CMD_NONE      = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MRD,
    S_MWR,
    S_SRD,
    S_SEX,
    S_FLUSH
  } seq_state_t;

  typedef struct packed {
    logic [MSG_W-1:0]     msg;
    logic [TIME_BITS-1:0] ts;
  } event_t;

  typedef struct packed {
    logic             kind;
    mode_t            mode;
    logic             mstart;
    logic [MSG_W-1:0] msg;
    logic             ovf;
  } res_t;

  typedef struct packed {
    mode_t                mode;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] loop_len;
    logic                 main_clr;
    logic                 played_clr;
    logic                 mstart;
    logic                 main_push;
    logic                 dub_push;
    logic                 ovf;
    logic                 merge;
    logic                 scan;
  } dec_t;

  typedef struct packed {
    logic             main_we;
    logic [IDX_W-1:0] main_waddr;
    event_t           main_wdata;
    logic             dub_we;
    logic [IDX_W-1:0] dub_waddr;
    event_t           dub_wdata;
    logic [IDX_W-1:0] raddr;
    logic             played_set;
    logic             played_clr_one;
    logic             played_clr_all;
  } store_req_t;

endpackage

// File: sv/mel_store.sv
module mel_store import mel_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  output event_t     main_rdata,
  output event_t     dub_rdata,
  output logic       played_rd
);

  event_t main_mem [EVENT_DEPTH];
  event_t dub_mem  [EVENT_DEPTH];
  logic [EVENT_DEPTH-1:0] played_r;

  always_ff @(posedge clk) begin
    if (req.main_we) begin
      main_mem[req.main_waddr] <= req.main_wdata;
    end
    main_rdata <= main_mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (req.dub_we) begin
      dub_mem[req.dub_waddr] <= req.dub_wdata;
    end
    dub_rdata <= dub_mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      played_r <= '0;
    end else if (req.played_clr_all) begin
      played_r <= '0;
    end else begin
      if (req.played_set) begin
        played_r[req.raddr] <= 1'b1;
      end
      if (req.played_clr_one) begin
        played_r[req.main_waddr] <= 1'b0;
      end
    end
  end

  assign played_rd = played_r[req.raddr];

endmodule

// File: sv/mel_cmd.sv
module mel_cmd import mel_pkg::*; (
  input  logic [CMD_W-1:0]     cmd,
  input  logic [BEAT_W-1:0]    beat,
  input  mode_t                mode,
  input  logic [TIME_BITS-1:0] elapsed,
  input  logic [TIME_BITS-1:0] loop_len,
  input  logic [BARS_W-1:0]    num_bars,
  input  logic [CNT_W-1:0]     main_count,
  input  logic [CNT_W-1:0]     dub_count,
  output dec_t                 dec
);

  logic [TIME_BITS-1:0] el_inc;
  logic [BEAT_W-1:0]    rec_end_beat;

  assign el_inc = (elapsed < TIME_MAX) ? elapsed + TIME_BITS'(1) : elapsed;
  assign rec_end_beat = BEAT_W'({num_bars, 2'b00}) + BEAT_W'(BEATS_PER_BAR);

  always_comb begin
    dec = '0;
    dec.mode     = mode;
    dec.elapsed  = elapsed;
    dec.loop_len = loop_len;
    case (cmd)
      CMD_TICK: begin
        dec.elapsed = el_inc;
        case (mode)
          MODE_CIN: begin
            if (beat >= BEAT_W'(BEATS_PER_BAR)) begin
              dec.elapsed = '0;
              dec.mode    = MODE_REC;
            end
          end
          MODE_REC: begin
            if (beat == rec_end_beat) begin
              dec.loop_len = el_inc;
              dec.elapsed  = '0;
              dec.mode     = MODE_PLAY;
            end
          end
          MODE_COUT: begin
            if (beat[1:0] == 2'b00) begin
              dec.loop_len = el_inc;
              dec.mode     = MODE_PLAY;
            end
          end
          MODE_PLAY, MODE_CIN_DUB, MODE_DUB: begin
            dec.scan = 1'b1;
            if (el_inc >= loop_len) begin
              dec.elapsed    = '0;
              dec.played_clr = 1'b1;
              if (mode == MODE_CIN_DUB) begin
                dec.mode = MODE_DUB;
              end else if (mode == MODE_DUB) begin
                dec.mode  = MODE_PLAY;
                dec.merge = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      CMD_MIDI_IN: begin
        if (mode == MODE_REC) begin
          if (main_count < CNT_W'(EVENT_DEPTH)) begin
            dec.main_push = 1'b1;
          end else begin
            dec.ovf = 1'b1;
          end
        end else if (mode == MODE_DUB) begin
          if (dub_count < CNT_W'(EVENT_DEPTH)) begin
            dec.dub_push = 1'b1;
          end else begin
            dec.ovf = 1'b1;
          end
        end
      end
      CMD_START_REC: begin
        dec.main_clr   = 1'b1;
        dec.played_clr = 1'b1;
        dec.mstart     = 1'b1;
        dec.mode       = MODE_CIN;
      end
      CMD_STOP_REC: begin
        if (mode == MODE_REC) begin
          dec.mode = MODE_COUT;
        end
      end
      CMD_START_PLAY: begin
        dec.mode    = MODE_PLAY;
        dec.elapsed = '0;
      end
      CMD_START_DUB: dec.mode = MODE_CIN_DUB;
      CMD_STOP_DUB:  dec.mode = MODE_PLAY;
      CMD_STOP_PLAY: dec.mode = MODE_IDLE;
      default: begin
      end
    endcase
  end

endmodule

// File: sv/midi_event_looper_unit.sv
// MIDI looper. A request that needs no store walk is accepted in S_IDLE and
// then posts its status result from S_FLUSH. A tick in a playing mode then
// walks the event store, reading each stored event (S_SRD, then S_SEX)
// through the single store read port, and at an overdub loop end it first
// copies the overdub events over (S_MRD, then S_MWR). An output stall can
// hold the walk and the flush. Results are held one deep so the last flag
// lands on the final result. in_stall is high while a request is being
// worked on.
module midi_event_looper_unit import mel_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [BARS_W-1:0]    cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [BEAT_W-1:0]    in_beat,
  input  logic [MSG_W-1:0]     in_midi_msg,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [2:0]           out_mode,
  output logic                 out_metronome_start,
  output logic [MSG_W-1:0]     out_msg,
  output logic                 out_overflow,
  output logic                 out_last
);

  seq_state_t state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  logic [BARS_W-1:0]    num_bars_r;
  logic [TIME_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [TIME_BITS-1:0] loop_len_r, loop_len_nxt;
  logic [CNT_W-1:0]     main_count_r, main_count_nxt;
  logic [CNT_W-1:0]     dub_count_r, dub_count_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  res_t hold_r, hold_nxt;
  res_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_last_r, out_last_nxt;

  dec_t       dec;
  store_req_t req;
  event_t     main_rdata, dub_rdata;
  logic       played_rd;
  logic       out_free;
  logic       accept;
  logic [CNT_W-1:0] idx_inc;

  mel_cmd u_cmd (
    .cmd        (in_cmd),
    .beat       (in_beat),
    .mode       (mode_r),
    .elapsed    (elapsed_r),
    .loop_len   (loop_len_r),
    .num_bars   (num_bars_r),
    .main_count (main_count_r),
    .dub_count  (dub_count_r),
    .dec        (dec)
  );

  mel_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .main_rdata (main_rdata),
    .dub_rdata  (dub_rdata),
    .played_rd  (played_rd)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign idx_inc  = CNT_W'(idx_r) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bars_r <= BARS_RESET;
    end else if (cfg_wr_en) begin
      num_bars_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_IDLE;
      elapsed_r    <= '0;
      loop_len_r   <= '0;
      main_count_r <= '0;
      dub_count_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      elapsed_r    <= elapsed_nxt;
      loop_len_r   <= loop_len_nxt;
      main_count_r <= main_count_nxt;
      dub_count_r  <= dub_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    elapsed_nxt    = elapsed_r;
    loop_len_nxt   = loop_len_r;
    main_count_nxt = main_count_r;
    dub_count_nxt  = dub_count_r;
    idx_nxt        = idx_r;
    hold_nxt       = hold_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    req            = '0;
    req.raddr      = idx_r;
    req.main_waddr = main_count_r[IDX_W-1:0];
    req.dub_waddr  = dub_count_r[IDX_W-1:0];
    req.main_wdata = '{msg: in_midi_msg, ts: elapsed_r};
    req.dub_wdata  = '{msg: in_midi_msg, ts: elapsed_r};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt     = dec.mode;
          elapsed_nxt  = dec.elapsed;
          loop_len_nxt = dec.loop_len;
          hold_nxt     = '{kind: 1'b0, mode: dec.mode, mstart: dec.mstart,
                           msg: '0, ovf: dec.ovf};
          idx_nxt      = '0;
          req.played_clr_all = dec.played_clr;
          if (dec.main_clr) begin
            main_count_nxt = '0;
          end
          if (dec.main_push) begin
            req.main_we        = 1'b1;
            req.played_clr_one = 1'b1;
            main_count_nxt     = main_count_r + CNT_W'(1);
          end
          if (dec.dub_push) begin
            req.dub_we    = 1'b1;
            dub_count_nxt = dub_count_r + CNT_W'(1);
          end
          if (dec.merge && dub_count_r != '0) begin
            state_nxt = S_MRD;
          end else if (dec.scan && main_count_r != '0) begin
            state_nxt = S_SRD;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_MRD: state_nxt = S_MWR;
      S_MWR: begin
        req.main_wdata = dub_rdata;
        if (main_count_r < CNT_W'(EVENT_DEPTH)) begin
          req.main_we        = 1'b1;
          req.played_clr_one = 1'b1;
          main_count_nxt     = main_count_r + CNT_W'(1);
        end else begin
          hold_nxt.ovf = 1'b1;
        end
        if (idx_inc == dub_count_r) begin
          dub_count_nxt = '0;
          idx_nxt       = '0;
          state_nxt     = S_SRD;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_MRD;
        end
      end
      S_SRD: state_nxt = S_SEX;
      S_SEX: begin
        if (main_rdata.ts <= elapsed_r && !played_rd) begin
          if (out_free) begin
            req.played_set = 1'b1;
            out_valid_nxt  = 1'b1;
            out_nxt        = hold_r;
            out_last_nxt   = 1'b0;
            hold_nxt       = '{kind: 1'b1, mode: mode_r, mstart: 1'b0,
                               msg: main_rdata.msg, ovf: 1'b0};
            if (idx_inc == main_count_r) begin
              state_nxt = S_FLUSH;
            end else begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = S_SRD;
            end
          end
        end else if (idx_inc == main_count_r) begin
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SRD;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = hold_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_r.kind;
  assign out_mode            = out_r.mode;
  assign out_metronome_start = out_r.mstart;
  assign out_msg             = out_r.msg;
  assign out_overflow        = out_r.ovf;
  assign out_last            = out_last_r;

  a_main_count: assert property (@(posedge clk) disable iff (!rst_n)
    main_count_r <= CNT_W'(EVENT_DEPTH))
    else $error("main store count past depth");

  a_dub_count: assert property (@(posedge clk) disable iff (!rst_n)
    dub_count_r <= CNT_W'(EVENT_DEPTH))
    else $error("overdub store count past depth");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without going busy");

  a_event_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind) |-> (!out_metronome_start && !out_overflow))
    else $error("event result carries status flags");

endmodule
